>>> design/fair_share_task_picker_defines.svh
// ----------------------------------------------------------------------------
// fair share task picker assertion macros
// concurrent assertion shorthands, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef FAIR_SHARE_TASK_PICKER_DEFINES_SVH
`define FAIR_SHARE_TASK_PICKER_DEFINES_SVH

// same-cycle implication
`define FSTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fstp_pkg.sv
// ----------------------------------------------------------------------------
// fstp_pkg
// shared types and codes of the fair share task picker
// ----------------------------------------------------------------------------
`default_nettype none
package fstp_pkg;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_CHARGE  = 2'd2;

    localparam logic [16:0] WEIGHT_RESET = 17'd1024;
    localparam int          DIV_STEPS    = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic write;
        logic scan;
    } ctl_t;

    typedef struct packed {
        logic is_charge;
        logic div_done;
        logic scan_done;
    } stat_t;

endpackage
`default_nettype wire

>>> design/fstp_ram.sv
// ----------------------------------------------------------------------------
// fstp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module fstp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> design/fstp_ctrl.sv
// ----------------------------------------------------------------------------
// fstp_ctrl
// sequencer: read slot, apply command, divide and write back (charge only), scan, deliver
// ----------------------------------------------------------------------------
`default_nettype none
module fstp_ctrl
    import fstp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output ctl_t       ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  state_next = stat.is_charge ? ST_DIV : ST_SCAN;
            ST_DIV:   if (stat.div_done) state_next = ST_WRITE;
            ST_WRITE: state_next = ST_SCAN;
            ST_SCAN:  if (stat.scan_done) state_next = ST_DONE;
            ST_DONE:  if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl          = '0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            ST_EXEC:  ctl.exec = 1'b1;
            ST_DIV:   ctl.div_step = 1'b1;
            ST_WRITE: ctl.write = 1'b1;
            ST_SCAN:  ctl.scan = 1'b1;
            ST_DONE:  out_valid = 1'b1;
            default:  ctl = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> design/fstp_datapath.sv
// ----------------------------------------------------------------------------
// fstp_datapath
// slot tables, restoring divider, queue totals and minimum scan
// ----------------------------------------------------------------------------
`default_nettype none
module fstp_datapath
    import fstp_pkg::*;
#(
    parameter int TASKS        = 16,
    parameter int WEIGHT_SCALE = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctl_t        ctl,
    output stat_t            stat,
    input  wire logic [1:0]  cmd,
    input  wire logic [3:0]  task_id,
    input  wire logic [63:0] start_vruntime,
    input  wire logic [16:0] task_weight,
    input  wire logic [47:0] exec_delta,
    output logic             status,
    output logic             picked_valid,
    output logic [3:0]       picked_task,
    output logic [63:0]      task_vruntime,
    output logic [63:0]      task_exec_time,
    output logic [4:0]       queued_count,
    output logic [20:0]      total_weight,
    output logic [63:0]      vruntime_mark
);

    localparam int IW = $clog2(TASKS);
    localparam int CW = $clog2(TASKS + 1);

    // latched transaction
    logic [1:0]  cmd_reg;
    logic [3:0]  id_reg;
    logic [63:0] start_reg;
    logic [16:0] win_reg;
    logic [47:0] delta_reg;

    logic [TASKS-1:0] queued_reg, vr_vld_reg, wt_vld_reg, ex_vld_reg;
    logic             vr_rv_reg, wt_rv_reg, ex_rv_reg;

    logic [4:0]  count_reg;
    logic [20:0] sum_reg;
    logic [63:0] mark_reg;

    logic        status_reg;
    logic [63:0] vres_reg, eres_reg, vr_reg, ex_reg;

    // divider
    logic [63:0] dq_reg;
    logic [16:0] rem_reg, dvs_reg;
    logic [6:0]  dcnt_reg;
    logic [17:0] rem_pre;
    logic [17:0] rem_sub;

    // scan
    logic [CW-1:0] scnt_reg;
    logic [IW-1:0] ridx_reg;
    logic          rpend_reg, found_reg;
    logic [IW-1:0] pick_reg;
    logic [63:0]   best_reg;

    logic [IW-1:0] slot, vr_raddr;
    logic          in_range, enq_ok, deq_ok;
    logic [63:0]   vr_rd, ex_rd, vr_eff, ex_eff, vr_new, scan_v, prod;
    logic [16:0]   wt_rd, wt_eff, w1;
    logic          vr_we, wt_we, ex_we;
    logic [63:0]   vr_wdata;

    assign slot     = IW'(id_reg);
    assign in_range = (int'(id_reg) < TASKS);
    assign vr_raddr = ctl.scan ? scnt_reg[IW-1:0] : slot;
    assign vr_eff   = vr_rv_reg ? vr_rd : 64'd0;
    assign ex_eff   = ex_rv_reg ? ex_rd : 64'd0;
    assign wt_eff   = wt_rv_reg ? wt_rd : WEIGHT_RESET;
    assign w1       = (win_reg == 17'd0) ? 17'd1 : win_reg;
    assign enq_ok   = in_range && (cmd_reg == CMD_ENQUEUE) && !queued_reg[slot];
    assign deq_ok   = in_range && (cmd_reg == CMD_DEQUEUE) && queued_reg[slot];
    assign vr_new   = vr_reg + dq_reg;
    assign prod     = 64'(delta_reg) * 64'(WEIGHT_SCALE);
    assign scan_v   = vr_rv_reg ? vr_rd : 64'd0;
    assign rem_pre  = {rem_reg, dq_reg[63]};
    assign rem_sub  = rem_pre - {1'b0, dvs_reg};

    assign vr_we    = (ctl.exec && enq_ok) || ctl.write;
    assign vr_wdata = ctl.write ? vr_new : start_reg;
    assign wt_we    = ctl.exec && enq_ok;
    assign ex_we    = ctl.write;

    fstp_ram #(.WIDTH(64), .DEPTH(TASKS)) u_vr_ram (
        .clk(clk), .we(vr_we), .waddr(slot), .wdata(vr_wdata),
        .raddr(vr_raddr), .rdata(vr_rd)
    );
    fstp_ram #(.WIDTH(17), .DEPTH(TASKS)) u_wt_ram (
        .clk(clk), .we(wt_we), .waddr(slot), .wdata(w1),
        .raddr(slot), .rdata(wt_rd)
    );
    fstp_ram #(.WIDTH(64), .DEPTH(TASKS)) u_ex_ram (
        .clk(clk), .we(ex_we), .waddr(slot), .wdata(ex_reg + 64'(delta_reg)),
        .raddr(slot), .rdata(ex_rd)
    );

    assign stat.is_charge = in_range && (cmd_reg == CMD_CHARGE);
    assign stat.div_done  = (dcnt_reg == 7'd0);
    assign stat.scan_done = (int'(scnt_reg) == TASKS) && !rpend_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        vr_rv_reg <= vr_vld_reg[vr_raddr];
        wt_rv_reg <= wt_vld_reg[slot];
        ex_rv_reg <= ex_vld_reg[slot];
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            id_reg    <= task_id;
            start_reg <= start_vruntime;
            win_reg   <= task_weight;
            delta_reg <= exec_delta;
        end
        if (ctl.exec)
        begin
            vr_reg   <= vr_eff;
            ex_reg   <= ex_eff;
            vres_reg <= in_range ? (enq_ok ? start_reg : vr_eff) : 64'd0;
            eres_reg <= in_range ? ex_eff : 64'd0;
            dq_reg   <= prod;
            dvs_reg  <= wt_eff;
            rem_reg  <= 17'd0;
        end
        if (ctl.div_step && dcnt_reg != 7'd0)
        begin
            if (!rem_sub[17])
            begin
                rem_reg <= rem_sub[16:0];
                dq_reg  <= {dq_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_pre[16:0];
                dq_reg  <= {dq_reg[62:0], 1'b0};
            end
        end
        if (ctl.write)
        begin
            vres_reg <= vr_new;
            eres_reg <= ex_reg + 64'(delta_reg);
        end
        if (ctl.scan)
        begin
            ridx_reg <= scnt_reg[IW-1:0];
            if (rpend_reg && queued_reg[ridx_reg] && (!found_reg || scan_v < best_reg))
            begin
                best_reg <= scan_v;
                pick_reg <= ridx_reg;
            end
        end
    end

    // control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg <= '0;
            vr_vld_reg <= '0;
            wt_vld_reg <= '0;
            ex_vld_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            mark_reg   <= '0;
            status_reg <= 1'b0;
            dcnt_reg   <= '0;
            scnt_reg   <= '0;
            rpend_reg  <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                scnt_reg  <= '0;
                rpend_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            if (ctl.exec)
            begin
                status_reg <= !(enq_ok || deq_ok || stat.is_charge);
                dcnt_reg   <= stat.is_charge ? 7'(DIV_STEPS) : 7'd0;
                if (enq_ok)
                begin
                    queued_reg[slot] <= 1'b1;
                    vr_vld_reg[slot] <= 1'b1;
                    wt_vld_reg[slot] <= 1'b1;
                    count_reg        <= count_reg + 5'd1;
                    sum_reg          <= sum_reg + 21'(w1);
                end
                if (deq_ok)
                begin
                    queued_reg[slot] <= 1'b0;
                    count_reg        <= count_reg - 5'd1;
                    sum_reg          <= sum_reg - 21'(wt_eff);
                end
            end
            if (ctl.div_step && dcnt_reg != 7'd0)
            begin
                dcnt_reg <= dcnt_reg - 7'd1;
            end
            if (ctl.write)
            begin
                vr_vld_reg[slot] <= 1'b1;
                ex_vld_reg[slot] <= 1'b1;
                if (vr_new > mark_reg)
                begin
                    mark_reg <= vr_new;
                end
            end
            if (ctl.scan)
            begin
                if (int'(scnt_reg) < TASKS)
                begin
                    scnt_reg  <= scnt_reg + CW'(1);
                    rpend_reg <= 1'b1;
                end
                else
                begin
                    rpend_reg <= 1'b0;
                end
                if (rpend_reg && queued_reg[ridx_reg])
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    assign status         = status_reg;
    assign picked_valid   = found_reg;
    assign picked_task    = found_reg ? 4'(pick_reg) : 4'd0;
    assign task_vruntime  = vres_reg;
    assign task_exec_time = eres_reg;
    assign queued_count   = count_reg;
    assign total_weight   = sum_reg;
    assign vruntime_mark  = mark_reg;

endmodule
`default_nettype wire

>>> design/fair_share_task_picker.sv
// ----------------------------------------------------------------------------
// fair share task picker
// table of task slots with virtual runtime, reporting the least-runtime task
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries one command transaction (enqueue,
// dequeue or charge) for one task slot; output channel out_valid/out_ready
// returns exactly one result transaction per command
// one transaction is handled at a time: in_ready is high only while idle
// charge commands for a valid slot run through the bit-per-cycle restoring
// divider (delta*scale/weight) and a write-back; every command ends with the
// scan that reads one slot vruntime per cycle from the ram, and a new command
// is accepted only after the previous result has been delivered
// reset empties the queue, clears totals and the high-water mark; slot
// tables read as zero runtime, weight 1024 and zero executed time until
// written, tracked by per-slot valid flags so no clearing pass is needed
// if the receiver stalls, the result holds on the outputs and no new
// command is taken until it is delivered
// ----------------------------------------------------------------------------
`default_nettype none
module fair_share_task_picker
    import fstp_pkg::*;
#(
    parameter int TASKS        = 16,
    parameter int WEIGHT_SCALE = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [3:0]  task_id,
    input  wire logic [63:0] start_vruntime,
    input  wire logic [16:0] task_weight,
    input  wire logic [47:0] exec_delta,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic             picked_valid,
    output logic [3:0]       picked_task,
    output logic [63:0]      task_vruntime,
    output logic [63:0]      task_exec_time,
    output logic [4:0]       queued_count,
    output logic [20:0]      total_weight,
    output logic [63:0]      vruntime_mark
);

    // command and status between sequencer and datapath
    ctl_t  ctl;
    stat_t stat;

    fstp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    fstp_datapath #(
        .TASKS        (TASKS),
        .WEIGHT_SCALE (WEIGHT_SCALE)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .task_id        (task_id),
        .start_vruntime (start_vruntime),
        .task_weight    (task_weight),
        .exec_delta     (exec_delta),
        .status         (status),
        .picked_valid   (picked_valid),
        .picked_task    (picked_task),
        .task_vruntime  (task_vruntime),
        .task_exec_time (task_exec_time),
        .queued_count   (queued_count),
        .total_weight   (total_weight),
        .vruntime_mark  (vruntime_mark)
    );

endmodule
`default_nettype wire

>>> design/fstp_checker.sv
// ----------------------------------------------------------------------------
// fstp_checker
// port-level checks of the fair share task picker
// ----------------------------------------------------------------------------
`default_nettype none
`include "fair_share_task_picker_defines.svh"
module fstp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        picked_valid,
    input wire logic [3:0]  picked_task,
    input wire logic [63:0] task_vruntime,
    input wire logic [4:0]  queued_count,
    input wire logic [20:0] total_weight
);

    `FSTP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(task_vruntime) && $stable(picked_task), "result dropped")
    `FSTP_ASSERT_NOW(a_excl, clk, rst_n, out_valid, !in_ready, "input taken while busy")
    `FSTP_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid,
        "no turnaround after accept")
    `FSTP_ASSERT_NOW(a_pick, clk, rst_n, out_valid, picked_valid == (queued_count != 5'd0),
        "pick disagrees with count")
    `FSTP_ASSERT_NOW(a_empty, clk, rst_n, out_valid && !picked_valid,
        picked_task == 4'd0 && total_weight == 21'd0, "empty queue not clean")

endmodule

bind fair_share_task_picker fstp_checker u_fstp_checker (.*);
`default_nettype wire
